[hdl/csmp_pkg.sv]
// Package for the byte stack with multi-pop.
// Holds the operation codes, controller states and the command and status
// structs shared by the controller, the datapath and the top level.
package csmp_pkg;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_MULTI = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_EXEC    = 8'b0000_0010,
		S_POPDATA = 8'b0000_0100,
		S_COMPACT = 8'b0000_1000,
		S_TOPRD   = 8'b0001_0000,
		S_TOPWAIT = 8'b0010_0000,
		S_COUNT   = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic load;
		logic push_wr;
		logic set_full;
		logic set_empty;
		logic rd_top;
		logic take_pop;
		logic dec_level;
		logic scan_start;
		logic scan_rd;
		logic compact;
		logic count;
		logic set_level;
		logic top_latch;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  empty;
		logic  full;
		logic  rd_more;
		logic  rv;
	} dp_stat_t;

endpackage

[hdl/char_stack_with_multipop_unit.sv]
// Top level of the byte stack with multi-pop: controller plus datapath.
// Depends on csmp_pkg, csmp_ctrl and csmp_dp.
//
//   Channel   Handshake              Payload
//   request   start / busy           mode, push_byte
//   result    done (one-cycle)       popped_byte, empty_error, full_error,
//                                    depth_now, top_repeats, distinct_values
//
// A request is taken when start is high and busy is low; one result follows.
// After the operation each request scans the entries left on the stack to count
// the repeats of the top byte and the distinct values; a push, pop or query that
// leaves the stack empty skips the scan. Multi-pop first compacts the M entries,
// M being the depth before it (nothing on an empty stack), one entry per cycle
// through the single memory read port, and reads the entries left once more for
// the repeat and distinct counts.
// Reset clears the fill level; the entry memory is left uninitialized.
// The result is shown for one cycle with done and cannot be stalled.
module char_stack_with_multipop_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] push_byte,
	output logic       done,
	output logic [7:0] popped_byte,
	output logic       empty_error,
	output logic       full_error,
	output logic [6:0] depth_now,
	output logic [6:0] top_repeats,
	output logic [6:0] distinct_values
);
	import csmp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	csmp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	csmp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.mode            (mode),
		.push_byte       (push_byte),
		.stat            (stat),
		.popped_byte     (popped_byte),
		.empty_error     (empty_error),
		.full_error      (full_error),
		.depth_now       (depth_now),
		.top_repeats     (top_repeats),
		.distinct_values (distinct_values)
	);

endmodule

[hdl/csmp_ctrl.sv]
// Controller state machine for the byte stack with multi-pop.
// Sequences push, pop, compaction and counting scans; depends on csmp_pkg.
module csmp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  csmp_pkg::dp_stat_t stat,
	output logic               busy,
	output logic               done,
	output csmp_pkg::dp_cmd_t  cmd
);
	import csmp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.mode)
					MODE_PUSH: begin
						if (stat.full) begin
							cmd.set_full = 1'b1;
						end else begin
							cmd.push_wr = 1'b1;
						end
						state_d = S_TOPRD;
					end
					MODE_POP, MODE_MULTI: begin
						if (stat.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = S_TOPRD;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_POPDATA;
						end
					end
					default: begin
						state_d = S_TOPRD;
					end
				endcase
			end
			S_POPDATA: begin
				cmd.take_pop  = 1'b1;
				cmd.top_latch = 1'b1;
				if (stat.mode == MODE_MULTI) begin
					cmd.scan_start = 1'b1;
					state_d        = S_COMPACT;
				end else begin
					cmd.dec_level = 1'b1;
					state_d       = S_TOPRD;
				end
			end
			S_COMPACT: begin
				cmd.compact = 1'b1;
				cmd.scan_rd = stat.rd_more;
				if (!stat.rd_more && !stat.rv) begin
					cmd.set_level = 1'b1;
					state_d       = S_TOPRD;
				end
			end
			S_TOPRD: begin
				cmd.scan_start = 1'b1;
				if (stat.empty) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_top = 1'b1;
					state_d    = S_TOPWAIT;
				end
			end
			S_TOPWAIT: begin
				cmd.top_latch = 1'b1;
				state_d       = S_COUNT;
			end
			S_COUNT: begin
				cmd.count   = 1'b1;
				cmd.scan_rd = stat.rd_more;
				if (!stat.rd_more && !stat.rv) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe lasted more than one cycle");

	a_compact_multi: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMPACT |-> stat.mode == MODE_MULTI)
		else $error("compaction entered for a mode other than multi-pop");

endmodule

[hdl/csmp_dp.sv]
// Datapath for the byte stack with multi-pop: entry memory, fill level,
// scan counters, seen-value flags and result registers; depends on csmp_pkg.
module csmp_dp #(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csmp_pkg::dp_cmd_t  cmd,
	input  logic [1:0]         mode,
	input  logic [7:0]         push_byte,
	output csmp_pkg::dp_stat_t stat,
	output logic [7:0]         popped_byte,
	output logic               empty_error,
	output logic               full_error,
	output logic [6:0]         depth_now,
	output logic [6:0]         top_repeats,
	output logic [6:0]         distinct_values
);
	import csmp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam logic [LW-1:0] FULL_LEVEL = LW'(STACK_DEPTH);

	logic [7:0]    mem [STACK_DEPTH];
	logic [7:0]    rdata_q;
	logic [7:0]    byte_q;
	logic [7:0]    top_q;
	logic [7:0]    popped_q;
	logic          empty_q;
	logic          full_q;
	mode_t         mode_q;
	logic [LW-1:0] level_q;
	logic [LW-1:0] rd_idx_q;
	logic [LW-1:0] wr_idx_q;
	logic [LW-1:0] rep_q;
	logic [LW-1:0] dist_q;
	logic          rv_q;
	logic [255:0]  seen_q;

	logic [LW-1:0] level_m1;
	logic          keep;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [7:0]    wdata;

	assign level_m1 = level_q - LW'(1);
	assign keep     = cmd.compact && rv_q && (rdata_q != top_q);
	assign wr_en    = cmd.push_wr || keep;
	assign waddr    = cmd.push_wr ? level_q[AW-1:0] : wr_idx_q[AW-1:0];
	assign wdata    = cmd.push_wr ? byte_q : rdata_q;
	assign rd_en    = cmd.rd_top || cmd.scan_rd;
	assign raddr    = cmd.rd_top ? level_m1[AW-1:0] : rd_idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode_t'(mode);
			byte_q   <= push_byte;
			popped_q <= '0;
			empty_q  <= 1'b0;
			full_q   <= 1'b0;
		end
		if (cmd.set_full) begin
			full_q <= 1'b1;
		end
		if (cmd.set_empty) begin
			empty_q <= 1'b1;
		end
		if (cmd.take_pop) begin
			popped_q <= rdata_q;
		end
		if (cmd.top_latch) begin
			top_q <= rdata_q;
		end
		if (cmd.scan_start) begin
			seen_q <= '0;
		end else if (cmd.count && rv_q) begin
			seen_q[rdata_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			rep_q    <= '0;
			dist_q   <= '0;
			rv_q     <= 1'b0;
		end else begin
			rv_q <= cmd.scan_rd;
			if (cmd.push_wr) begin
				level_q <= level_q + LW'(1);
			end else if (cmd.dec_level) begin
				level_q <= level_m1;
			end else if (cmd.set_level) begin
				level_q <= wr_idx_q;
			end
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				rep_q    <= '0;
				dist_q   <= '0;
			end else begin
				if (cmd.scan_rd) begin
					rd_idx_q <= rd_idx_q + LW'(1);
				end
				if (keep) begin
					wr_idx_q <= wr_idx_q + LW'(1);
				end
				if (cmd.count && rv_q) begin
					if (rdata_q == top_q) begin
						rep_q <= rep_q + LW'(1);
					end
					if (!seen_q[rdata_q]) begin
						dist_q <= dist_q + LW'(1);
					end
				end
			end
		end
	end

	assign stat.mode    = mode_q;
	assign stat.empty   = (level_q == '0);
	assign stat.full    = (level_q == FULL_LEVEL);
	assign stat.rd_more = (rd_idx_q != level_q);
	assign stat.rv      = rv_q;

	assign popped_byte     = popped_q;
	assign empty_error     = empty_q;
	assign full_error      = full_q;
	assign depth_now       = 7'(level_q);
	assign top_repeats     = 7'(rep_q);
	assign distinct_values = 7'(dist_q);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= FULL_LEVEL)
		else $error("fill level exceeded the stack depth");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= rd_idx_q)
		else $error("compaction write index passed the read index");

	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= rd_idx_q && dist_q <= rd_idx_q)
		else $error("a count exceeded the number of entries scanned");

	a_no_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> level_q != FULL_LEVEL)
		else $error("write issued onto a full stack");

endmodule
